// ===== rtl/core/pstep_pkg.sv =====
// shared types and constants of the particle step and neighbour mask block
`timescale 1ns / 1ps
`default_nettype none

package pstep_pkg;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WALL_BOUND      = 2'd2;

	// configuration reset values
	localparam logic [8:0]  ACTIVE_RESET = 9'd256;
	localparam logic [22:0] LIMIT_RESET  = 23'd209715;
	localparam logic [22:0] BOUND_RESET  = 23'd1048576;

	// fixed field and sweep geometry
	localparam int LANES     = 4;
	localparam int LANE_W    = 2;
	localparam int ROW_W     = 6;
	localparam int MASK_W    = 64;

	typedef struct packed {
		logic [8:0]  active_count;
		logic [22:0] neighbour_limit;
		logic [22:0] wall_bound;
	} pstep_cfg_t;

	typedef struct packed {
		logic             load_we;
		logic             step_capture;
		logic             prep;
		logic             commit;
		logic             issue;
		logic             issue_last;
		logic [ROW_W-1:0] row;
	} pstep_cmd_t;

	typedef struct packed {
		logic       pipe_busy;
		logic [1:0] last_chunk_sel;
	} pstep_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pstep_ctrl.sv =====
// sequencer for load, step update and neighbour sweep
`timescale 1ns / 1ps
`default_nettype none

module pstep_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      op,
	input  pstep_pkg::pstep_status_t  status,
	output logic                      busy,
	output pstep_pkg::pstep_cmd_t     cmd
);
	import pstep_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_nxt;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             last_row;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign last_row = (row_q[3:0] == 4'hF) && (row_q[5:4] == status.last_chunk_sel);

	always_comb begin
		cmd              = '0;
		cmd.load_we      = accept && (op == OP_LOAD);
		cmd.step_capture = accept && (op == OP_STEP);
		cmd.prep         = (state_q == ST_FETCH);
		cmd.commit       = (state_q == ST_UPDATE);
		cmd.issue        = (state_q == ST_SWEEP);
		cmd.issue_last   = (state_q == ST_SWEEP) && last_row;
		cmd.row          = row_q;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_STEP)) state_nxt = ST_FETCH;
			end
			ST_FETCH:  state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_SWEEP;
			ST_SWEEP: begin
				if (last_row) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_UPDATE) row_q <= '0;
			else if (state_q == ST_SWEEP) row_q <= row_q + ROW_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pstep_dp.sv =====
// particle stores, wall reflection update and four-lane distance pipeline
`timescale 1ns / 1ps
`default_nettype none

module pstep_dp #(
	parameter int MAX_PARTICLES = 256,
	parameter int COORD_BITS    = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pstep_pkg::pstep_cmd_t           cmd,
	input  pstep_pkg::pstep_cfg_t           cfg,
	input  logic [7:0]                      index,
	input  logic signed [23:0]              load_x,
	input  logic signed [23:0]              load_y,
	input  logic signed [23:0]              load_z,
	input  logic signed [23:0]              load_vx,
	input  logic signed [23:0]              load_vy,
	input  logic signed [23:0]              load_vz,
	output pstep_pkg::pstep_status_t        status,
	output logic                            result_valid,
	output logic [1:0]                      chunk_index,
	output logic [63:0]                     neighbour_bits,
	output logic                            last_chunk,
	output logic signed [23:0]              new_x,
	output logic signed [23:0]              new_y,
	output logic signed [23:0]              new_z
);
	import pstep_pkg::*;

	localparam int CB         = COORD_BITS;
	localparam int SLOT_W     = $clog2(MAX_PARTICLES);
	localparam int BANK_AW    = SLOT_W - LANE_W;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int VEL_DEPTH  = 1 << SLOT_W;
	localparam int CW         = (SLOT_W > 9) ? SLOT_W : 9;
	localparam int EW         = 34;
	localparam int DW         = CB + 3;
	localparam int LW         = (DW > 23) ? DW : 23;
	localparam logic [8:0] CNT_LIMIT = (MAX_PARTICLES < 256) ? 9'(MAX_PARTICLES) : 9'd256;
	localparam logic signed [32:0] CMAX = 33'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [32:0] CMIN = 33'(-(64'sd1 <<< (CB - 1)));

	function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] idx);
		logic [12:0] v;
		v = {5'd0, idx};
		for (int k = 0; k < 3; k++) begin
			if (v >= 13'(MAX_PARTICLES)) v = v - 13'(MAX_PARTICLES);
		end
		return v[SLOT_W-1:0];
	endfunction

	function automatic logic signed [CB-1:0] sat_wide(input logic signed [32:0] w);
		logic signed [CB-1:0] r;
		if (w > CMAX) r = CMAX[CB-1:0];
		else if (w < CMIN) r = CMIN[CB-1:0];
		else r = w[CB-1:0];
		return r;
	endfunction

	function automatic logic [23:0] to_field(input logic signed [CB-1:0] p);
		logic signed [32:0] w;
		w = 33'(p);
		return w[23:0];
	endfunction

	// address generation
	logic [SLOT_W-1:0]        slot_in;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        wr_slot;
	logic [BANK_AW-1:0]       wr_row;
	logic [BANK_AW+ROW_W-1:0] row_wide;
	logic [BANK_AW-1:0]       rd_row;
	logic [LANES-1:0]         pos_we;
	logic                     vel_we;

	assign slot_in  = slot_of(index);
	assign wr_slot  = cmd.load_we ? slot_in : slot_q;
	assign wr_row   = wr_slot[SLOT_W-1:LANE_W];
	assign row_wide = (BANK_AW + ROW_W)'(cmd.row);
	assign rd_row   = cmd.issue ? row_wide[BANK_AW-1:0] : slot_in[SLOT_W-1:LANE_W];
	assign vel_we   = cmd.load_we || cmd.commit;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pos_we[l] = vel_we && (wr_slot[LANE_W-1:0] == LANE_W'(l));
		end
	end

	// load and update write data
	logic signed [23:0]   ld_pos [3];
	logic signed [23:0]   ld_vel [3];
	logic signed [CB-1:0] new_pos [3];
	logic signed [CB-1:0] new_vel [3];
	logic signed [CB-1:0] pos_wdata [3];
	logic signed [CB-1:0] vel_wdata [3];

	assign ld_pos[0] = load_x;
	assign ld_pos[1] = load_y;
	assign ld_pos[2] = load_z;
	assign ld_vel[0] = load_vx;
	assign ld_vel[1] = load_vy;
	assign ld_vel[2] = load_vz;

	// stores: positions banked by slot modulo four, velocities flat
	logic signed [CB-1:0] rd_pos_s1 [3][LANES];
	logic signed [CB-1:0] rd_vel_q [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign pos_wdata[a] = cmd.load_we ? sat_wide(33'(ld_pos[a])) : new_pos[a];
		assign vel_wdata[a] = cmd.load_we ? sat_wide(33'(ld_vel[a])) : new_vel[a];

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic signed [CB-1:0] bank_mem [BANK_DEPTH];
			always_ff @(posedge clk) begin
				if (pos_we[l]) bank_mem[wr_row] <= pos_wdata[a];
				rd_pos_s1[a][l] <= bank_mem[rd_row];
			end
		end

		logic signed [CB-1:0] vel_mem [VEL_DEPTH];
		always_ff @(posedge clk) begin
			if (vel_we) vel_mem[wr_slot] <= vel_wdata[a];
			rd_vel_q[a] <= vel_mem[slot_in];
		end
	end

	// reflection: both candidate sums first, then select and saturate
	logic signed [CB:0]   spos_c [3];
	logic signed [CB:0]   sneg_c [3];
	logic signed [CB:0]   negv_c [3];
	logic signed [CB-1:0] nv_c [3];
	logic signed [CB-1:0] p_sel [3];
	logic                 flip_c [3];
	logic signed [EW-1:0] se_c [3];
	logic signed [EW-1:0] bnd;

	logic signed [CB:0]   spos_q [3];
	logic signed [CB:0]   sneg_q [3];
	logic signed [CB-1:0] nv_q [3];
	logic signed [CB-1:0] v_q [3];
	logic                 flip_q [3];
	logic signed [CB-1:0] pos_q [3];

	assign bnd = $signed(EW'(cfg.wall_bound));

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			p_sel[a]  = rd_pos_s1[a][slot_q[LANE_W-1:0]];
			spos_c[a] = (CB + 1)'(p_sel[a]) + (CB + 1)'(rd_vel_q[a]);
			negv_c[a] = -((CB + 1)'(rd_vel_q[a]));
			nv_c[a]   = sat_wide(33'(negv_c[a]));
			sneg_c[a] = (CB + 1)'(p_sel[a]) + (CB + 1)'(nv_c[a]);
			se_c[a]   = EW'(spos_c[a]);
			flip_c[a] = (se_c[a] > bnd) || (se_c[a] < -bnd);
			new_pos[a] = sat_wide(33'(flip_q[a] ? sneg_q[a] : spos_q[a]));
			new_vel[a] = flip_q[a] ? nv_q[a] : v_q[a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_capture) slot_q <= slot_in;
		if (cmd.prep) begin
			for (int a = 0; a < 3; a++) begin
				spos_q[a] <= spos_c[a];
				sneg_q[a] <= sneg_c[a];
				nv_q[a]   <= nv_c[a];
				v_q[a]    <= rd_vel_q[a];
				flip_q[a] <= flip_c[a];
			end
		end
		if (cmd.commit) begin
			for (int a = 0; a < 3; a++) pos_q[a] <= new_pos[a];
		end
	end

	// sweep pipeline: read, difference, magnitude, sum and compare
	logic [8:0]           count;
	logic [8:0]           count_m1;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic [ROW_W-1:0]     row_s1, row_s2, row_s3, row_s4;
	logic [LANES-1:0]     ok_s2, ok_s3;
	logic signed [CB:0]   diff_s2 [3][LANES];
	logic [CB:0]          mag_s3 [3][LANES];
	logic [LANES-1:0]     hit_s4;
	logic [LW-1:0]        dist_c [LANES];
	logic [LANES-1:0]     ok_c;
	logic [7:0]           j_c [LANES];
	logic [MASK_W-1:0]    shift_q;
	logic                 result_valid_q;
	logic [1:0]           chunk_index_q;
	logic [MASK_W-1:0]    bits_q;
	logic                 last_chunk_q;

	assign count    = (cfg.active_count > CNT_LIMIT) ? CNT_LIMIT : cfg.active_count;
	assign count_m1 = count - 9'd1;

	always_comb begin
		status.pipe_busy      = valid_s1 || valid_s2 || valid_s3 || valid_s4;
		status.last_chunk_sel = (count == 9'd0) ? 2'd0 : count_m1[7:6];
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			j_c[l]  = {row_s1, LANE_W'(l)};
			ok_c[l] = (CW'(j_c[l]) > CW'(slot_q)) && (CW'(j_c[l]) < CW'(count));
			dist_c[l] = LW'(mag_s3[0][l]) + LW'(mag_s3[1][l]) + LW'(mag_s3[2][l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= cmd.issue;
			valid_s2       <= valid_s1;
			valid_s3       <= valid_s2;
			valid_s4       <= valid_s3;
			result_valid_q <= valid_s4 && (row_s4[3:0] == 4'hF);
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= cmd.row;
		last_s1 <= cmd.issue_last;
		row_s2  <= row_s1;
		last_s2 <= last_s1;
		row_s3  <= row_s2;
		last_s3 <= last_s2;
		row_s4  <= row_s3;
		last_s4 <= last_s3;
		ok_s2   <= ok_c;
		ok_s3   <= ok_s2;
		for (int a = 0; a < 3; a++) begin
			for (int l = 0; l < LANES; l++) begin
				diff_s2[a][l] <= (CB + 1)'(pos_q[a]) - (CB + 1)'(rd_pos_s1[a][l]);
				mag_s3[a][l]  <= (diff_s2[a][l] < 0) ? unsigned'(-diff_s2[a][l])
				                                     : unsigned'(diff_s2[a][l]);
			end
		end
		for (int l = 0; l < LANES; l++) begin
			hit_s4[l] <= (dist_c[l] <= LW'(cfg.neighbour_limit)) && ok_s3[l];
		end
		// oldest row lands in the low nibble after sixteen shifts
		if (valid_s4) begin
			shift_q <= {hit_s4, shift_q[MASK_W-1:LANES]};
			if (row_s4[3:0] == 4'hF) begin
				bits_q        <= {hit_s4, shift_q[MASK_W-1:LANES]};
				chunk_index_q <= row_s4[5:4];
				last_chunk_q  <= last_s4;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign chunk_index    = chunk_index_q;
	assign neighbour_bits = bits_q;
	assign last_chunk     = last_chunk_q;
	assign new_x          = to_field(pos_q[0]);
	assign new_y          = to_field(pos_q[1]);
	assign new_z          = to_field(pos_q[2]);

endmodule

`default_nettype wire

// ===== rtl/core/particle_step_and_neighbour_mask.sv =====
// top level of the particle step and neighbour mask block
`timescale 1ns / 1ps
`default_nettype none

// Particle store with wall reflection and a neighbour mask, Q3.20 fixed point.
// An item is taken when start is high and busy is low. A load item (op 0)
// writes one slot and gives no result. A step item (op 1) reflects and moves
// the slot's particle, then sweeps the later slots below the active count,
// four slots a cycle through banked position memories and a four-lane
// distance pipeline, and gives one 64-bit mask chunk per 64 slots (one to
// four chunks). A step holds busy through a fetch state that registers the
// reflection sums, an update state that writes the particle back, sixteen
// sweep rows per chunk, and a drain that empties the four pipeline stages
// and shows the final chunk. Each chunk is shown for exactly one cycle with
// result_valid high and cannot be held off; chunks come sixteen sweep rows
// apart. new_x/new_y/new_z carry the stepped position on every chunk. Slots
// that were never loaded hold undefined data, there is no clearing pass
// after reset. Configuration writes are always ready and are meant to be
// issued while busy is low.
module particle_step_and_neighbour_mask #(
	parameter int MAX_PARTICLES = 256,
	parameter int COORD_BITS    = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command side
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic [7:0]                           index,
	input  logic signed [23:0]                   load_x,
	input  logic signed [23:0]                   load_y,
	input  logic signed [23:0]                   load_z,
	input  logic signed [23:0]                   load_vx,
	input  logic signed [23:0]                   load_vy,
	input  logic signed [23:0]                   load_vz,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pstep_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pstep_pkg::CFG_DATA_W-1:0]     cfg_data,
	// result strobe and payload
	output logic                                 result_valid,
	output logic [1:0]                           chunk_index,
	output logic [63:0]                          neighbour_bits,
	output logic                                 last_chunk,
	output logic signed [23:0]                   new_x,
	output logic signed [23:0]                   new_y,
	output logic signed [23:0]                   new_z
);
	import pstep_pkg::*;

	pstep_cfg_t    cfg_q;
	pstep_cmd_t    cmd;
	pstep_status_t status;

	// register writes never stall; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_count    <= ACTIVE_RESET;
			cfg_q.neighbour_limit <= LIMIT_RESET;
			cfg_q.wall_bound      <= BOUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_COUNT:    cfg_q.active_count    <= cfg_data[8:0];
				CFG_NEIGHBOUR_LIMIT: cfg_q.neighbour_limit <= cfg_data;
				CFG_WALL_BOUND:      cfg_q.wall_bound      <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: accepts transactions and steps through fetch, update, sweep and drain
	pstep_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// stores, reflection arithmetic and the distance lanes
	pstep_dp #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.COORD_BITS    (COORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg_q),
		.index          (index),
		.load_x         (load_x),
		.load_y         (load_y),
		.load_z         (load_z),
		.load_vx        (load_vx),
		.load_vy        (load_vy),
		.load_vz        (load_vz),
		.status         (status),
		.result_valid   (result_valid),
		.chunk_index    (chunk_index),
		.neighbour_bits (neighbour_bits),
		.last_chunk     (last_chunk),
		.new_x          (new_x),
		.new_y          (new_y),
		.new_z          (new_z)
	);

`ifndef SYNTHESIS
	// a chunk that is not the last one means the step is still in progress
	a_mid_chunk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_chunk) |-> busy)
		else $error("non-final chunk while block is idle");

	// chunks are sixteen sweep rows apart, never in adjacent cycles
	a_chunk_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("chunk strobes in consecutive cycles");

	// a load transaction produces no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_LOAD)) |=> !result_valid)
		else $error("result strobe after a load");

	// a step transaction occupies the block
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_STEP)) |=> busy)
		else $error("step accepted without going busy");
`endif

endmodule

`default_nettype wire
